// ===== hdl/baseline_tracking_pulse_counter_top_assert.svh =====
// Assertion macros for the baseline tracking pulse counter.
`ifndef BASELINE_TRACKING_PULSE_COUNTER_TOP_ASSERT_SVH
`define BASELINE_TRACKING_PULSE_COUNTER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BTPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BTPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/btpc_pkg.sv =====
// Package: widths, reset levels and register indexes of the pulse counter.
`timescale 1ns / 1ps
package btpc_pkg;

  localparam int LevelW  = 10;
  localparam int CeilW   = LevelW + 1;
  localparam int CountW  = 32;
  localparam int OffsetW = 8;
  localparam int MarginW = 6;
  localparam int StepW   = 4;
  localparam int DecayW  = 4;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 8;

  localparam logic [LevelW-1:0]  LEVEL_MAX   = 10'd1023;
  localparam logic [LevelW-1:0]  START_LEVEL = 10'd200;
  localparam logic [CeilW-1:0]   CEIL_RESET  = 11'd1023;

  localparam logic [OffsetW-1:0] OFFSET_RESET = 8'd40;
  localparam logic [MarginW-1:0] MARGIN_RESET = 6'd5;
  localparam logic [StepW-1:0]   STEP_RESET   = 4'd2;
  localparam logic [DecayW-1:0]  DECAY_RESET  = 4'd3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DIP_OFFSET       = 3'd0,
    REG_CEILING_MARGIN   = 3'd1,
    REG_CLIMB_STEP       = 3'd2,
    REG_DECAY_INTERVAL   = 3'd3,
    REG_BLINK_ENABLE     = 3'd4
  } cfg_reg_t;

endpackage

// ===== hdl/baseline_tracking_pulse_counter_top.sv =====
// Baseline tracking pulse counter: sample smoothing, baseline, dip detection, counter.
`timescale 1ns / 1ps
// Takes one 10-bit sample per beat and returns one result per beat. Each beat
// works on the sample held from the previous beat (200 after reset): it averages
// it with the last smoothed level, moves the baseline, compares against
// baseline minus offset and bumps a wrapping 32-bit count when a dip starts.
// Throughput is one sample per clock while no result is stalled; the result
// is registered in the cycle after acceptance by the single register stage that
// holds both the tracking state and the result. A result waiting on a stalled
// output holds off input; a new sample is taken in the same cycle the pending
// result is taken, so back-to-back beats run at full rate. Register writes take
// effect at the next edge and must only be issued while no result is pending.
module baseline_tracking_pulse_counter_top
  import btpc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [CfgIdxW-1:0]        cfg_index,
  input  logic [CfgW-1:0]           cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [LevelW-1:0]         sample,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [CountW-1:0]         bubble_total,
  output logic                      bubble_start,
  output logic                      bubble_end,
  output logic                      below_threshold,
  output logic                      flash_on,
  output logic                      flash_off,
  output logic                      flash_busy,
  output logic [LevelW-1:0]         smoothed_level,
  output logic [LevelW-1:0]         baseline_level,
  output logic signed [CeilW-1:0]   threshold_level
);

  // configuration
  logic [OffsetW-1:0] dip_offset;
  logic [MarginW-1:0] ceiling_margin;
  logic [StepW-1:0]   climb_step;
  logic [DecayW-1:0]  decay_interval;
  logic               blink_enable;

  // tracking state
  logic [LevelW-1:0]  held_sample;
  logic [LevelW-1:0]  smoothed, smoothed_next;
  logic [LevelW-1:0]  base, base_next;
  logic [CeilW-1:0]   ceiling, ceiling_next;
  logic [DecayW-1:0]  decay_count, decay_count_next;
  logic               in_dip, in_dip_next;
  logic [CountW-1:0]  dip_counter, dip_counter_next;
  logic               busy_flag, busy_flag_next;

  // per-beat result bits
  logic               start_next, end_next;
  logic signed [CeilW-1:0] thr_next;
  logic               start_q, end_q, flash_on_q, flash_off_q;
  logic signed [CeilW-1:0] threshold;

  logic [CeilW-1:0]   smooth_sum;
  logic [CeilW-1:0]   climb_sum;
  logic [DecayW-1:0]  decay_inc;
  logic               dip_hit;
  logic               in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dip_offset       <= OFFSET_RESET;
      ceiling_margin   <= MARGIN_RESET;
      climb_step       <= STEP_RESET;
      decay_interval   <= DECAY_RESET;
      blink_enable     <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DIP_OFFSET:       dip_offset       <= cfg_data[OffsetW-1:0];
        REG_CEILING_MARGIN:   ceiling_margin   <= cfg_data[MarginW-1:0];
        REG_CLIMB_STEP:       climb_step       <= cfg_data[StepW-1:0];
        REG_DECAY_INTERVAL:   decay_interval   <= cfg_data[DecayW-1:0];
        REG_BLINK_ENABLE:     blink_enable     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    smooth_sum       = {1'b0, smoothed} + {1'b0, held_sample};
    smoothed_next    = smooth_sum[CeilW-1:1];
    climb_sum        = {1'b0, base} + {{(CeilW-StepW){1'b0}}, climb_step};
    decay_inc        = decay_count + 1'b1;
    base_next        = base;
    ceiling_next     = ceiling;
    decay_count_next = decay_count;

    if (smoothed_next >= base) begin
      if ({1'b0, smoothed_next} > ceiling) begin
        // suspect rise: climb by the configured step, saturating at full scale
        base_next = (climb_sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : climb_sum[LevelW-1:0];
      end else begin
        base_next        = smoothed_next;
        decay_count_next = '0;
      end
      ceiling_next = {1'b0, base_next} + {{(CeilW-MarginW){1'b0}}, ceiling_margin};
    end else begin
      if (decay_inc >= decay_interval) begin
        decay_count_next = '0;
        base_next        = base - 1'b1;
      end else begin
        decay_count_next = decay_inc;
      end
    end

    thr_next = $signed({1'b0, base_next} - {{(CeilW-OffsetW){1'b0}}, dip_offset});
    dip_hit  = $signed({1'b0, smoothed_next}) <= thr_next;

    start_next       = 1'b0;
    end_next         = 1'b0;
    in_dip_next      = in_dip;
    busy_flag_next   = busy_flag;
    dip_counter_next = dip_counter;
    if (dip_hit && !in_dip) begin
      start_next       = 1'b1;
      in_dip_next      = 1'b1;
      busy_flag_next   = busy_flag || blink_enable;
      dip_counter_next = dip_counter + 1'b1;
    end else if (!dip_hit && in_dip) begin
      end_next       = 1'b1;
      in_dip_next    = 1'b0;
      busy_flag_next = 1'b0;
    end
  end

  // state and result move together on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      held_sample <= START_LEVEL;
      smoothed    <= START_LEVEL;
      base        <= START_LEVEL;
      ceiling     <= CEIL_RESET;
      decay_count <= '0;
      in_dip      <= 1'b0;
      dip_counter <= '0;
      busy_flag   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (in_fire) begin
        held_sample <= sample;
        smoothed    <= smoothed_next;
        base        <= base_next;
        ceiling     <= ceiling_next;
        decay_count <= decay_count_next;
        in_dip      <= in_dip_next;
        dip_counter <= dip_counter_next;
        busy_flag   <= busy_flag_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      start_q     <= start_next;
      end_q       <= end_next;
      flash_on_q  <= start_next && blink_enable;
      flash_off_q <= end_next && blink_enable;
      threshold   <= thr_next;
    end
  end

  assign bubble_total    = dip_counter;
  assign bubble_start    = start_q;
  assign bubble_end      = end_q;
  assign below_threshold = in_dip;
  assign flash_on        = flash_on_q;
  assign flash_off       = flash_off_q;
  assign flash_busy      = busy_flag;
  assign smoothed_level  = smoothed;
  assign baseline_level  = base;
  assign threshold_level = threshold;

`include "baseline_tracking_pulse_counter_top_assert.svh"

  `BTPC_ASSERT_NEXT(a_count_step, in_fire && start_next,
    bubble_total == $past(bubble_total) + 1'b1, "bubble count did not advance on a start")
  `BTPC_ASSERT_NEXT(a_count_hold, in_fire && !start_next,
    bubble_total == $past(bubble_total), "bubble count moved without a start")
  `BTPC_ASSERT_NOW(a_start_end_excl, out_valid,
    !(bubble_start && bubble_end), "dip start and end in the same beat")
  `BTPC_ASSERT_NOW(a_start_in_dip, out_valid && bubble_start,
    below_threshold, "dip start without dip state")
  `BTPC_ASSERT_NOW(a_busy_needs_dip, flash_busy,
    below_threshold, "flash busy outside a dip")

endmodule
